FILE: sv/bitmap_allocation_map_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap allocation map
// Concurrent checks, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_ALLOCATION_MAP_CORE_ASSERT_SVH
`define BITMAP_ALLOCATION_MAP_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define BAM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bitmap map assertion failed");

// condition must never be seen outside reset
`define BAM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bitmap map forbidden condition");

`else

`define BAM_ASSERT(lbl, clk, rst_n, prop)
`define BAM_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/bam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocation map package
// Shared types and constants for the map core and its sub-blocks.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIDX_W = 5;
  localparam int unsigned POS_W  = 10;

  localparam logic [7:0]  ACTIVE_RESET = 8'd128;
  localparam logic [10:0] POS_LIMIT    = 11'd1024;

  typedef enum logic [1:0] {
    FN_FIND  = 2'd0,
    FN_SET   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_TEST  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_ERROR     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [WIDX_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_cmd_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] found_position;
    logic             bit_value;
  } result_t;

endpackage

FILE: sv/bam_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one map operation per beat.
// ----------------------------------------------------------------------------
interface bam_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [9:0] bit_position;
  logic       search_value;

  modport source (output valid, output func, output bit_position,
                  output search_value, input ready);
  modport sink   (input valid, input func, input bit_position,
                  input search_value, output ready);
endinterface

FILE: sv/bam_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bam_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] found_position;
  logic       bit_value;

  modport source (output valid, output status, output found_position,
                  output bit_value, input ready);
  modport sink   (input valid, input status, input found_position,
                  input bit_value, output ready);
endinterface

FILE: sv/bam_map_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word store
// Single-port synchronous RAM of 32-bit words with per-word valid flags;
// a word never written reads as zero, so reset needs no clearing pass.
// ----------------------------------------------------------------------------
module bam_map_mem #(
  parameter int unsigned Words = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bam_pkg::mem_cmd_t          cmd_i,
  output logic [bam_pkg::WORD_W-1:0] rdata_o
);

  localparam int unsigned AW = (Words > 1) ? $clog2(Words) : 1;

  logic [bam_pkg::WORD_W-1:0] mem_q [Words];
  logic [Words-1:0]           vld_q;
  logic [bam_pkg::WORD_W-1:0] rdata_q;
  logic                       rvld_q;
  logic [AW-1:0]              addr;

  assign addr = cmd_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr] <= cmd_i.wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        vld_q[addr] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rvld_q <= vld_q[addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: sv/bam_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap map sequencer
// Decodes a request, runs read-modify-write for set/clear, a read for test
// and a word-by-word scan with a priority encoder for find, or an error.
// ----------------------------------------------------------------------------
module bam_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 eff_bytes_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic [1:0]                 func_i,
  input  logic [9:0]                 bit_position_i,
  input  logic                       search_value_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output bam_pkg::result_t           res_o,
  output bam_pkg::mem_cmd_t          mem_cmd_o,
  input  logic [bam_pkg::WORD_W-1:0] mem_rdata_i
);

  bam_pkg::state_e  state_q, state_d;
  bam_pkg::func_e   func_q, func_d;
  logic [9:0]       pos_q, pos_d;
  logic             want_q, want_d;
  logic [10:0]      lim_q, lim_d;
  logic [4:0]       widx_q, widx_d;
  bam_pkg::result_t res_q, res_d;

  logic [10:0] bits;
  logic [10:0] lim_m1;
  logic [4:0]  last_idx;
  logic        last_word;
  logic [31:0] word_mask;
  logic [31:0] match;
  logic [4:0]  first_hit;
  logic [31:0] bit_sel;

  function automatic logic [4:0] ffs32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  assign bits      = {eff_bytes_i, 3'b000};
  assign lim_m1    = lim_q - 11'd1;
  assign last_idx  = lim_m1[9:5];
  assign last_word = (widx_q == last_idx);
  // partial last word keeps only positions below the limit
  assign word_mask = (last_word && (lim_q[4:0] != 5'd0))
                   ? ((32'd1 << lim_q[4:0]) - 32'd1) : '1;
  assign match     = (want_q ? mem_rdata_i : ~mem_rdata_i) & word_mask;
  assign first_hit = ffs32(match);
  assign bit_sel   = 32'd1 << pos_q[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bam_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    pos_q  <= pos_d;
    want_q <= want_d;
    lim_q  <= lim_d;
    widx_q <= widx_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    pos_d       = pos_q;
    want_d      = want_q;
    lim_d       = lim_q;
    widx_d      = widx_q;
    res_d       = res_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_cmd_o   = '0;

    unique case (state_q)
      bam_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          func_d = bam_pkg::func_e'(func_i);
          pos_d  = bit_position_i;
          want_d = search_value_i;
          res_d  = '{status: bam_pkg::ST_ERROR, found_position: '0, bit_value: 1'b0};
          if (bits == 11'd0) begin
            state_d = bam_pkg::S_DONE;
          end else if (bam_pkg::func_e'(func_i) == bam_pkg::FN_FIND) begin
            lim_d          = (bits > bam_pkg::POS_LIMIT) ? bam_pkg::POS_LIMIT : bits;
            widx_d         = '0;
            mem_cmd_o.rd   = 1'b1;
            mem_cmd_o.addr = '0;
            state_d        = bam_pkg::S_SCAN;
          end else if ({1'b0, bit_position_i} < bits) begin
            mem_cmd_o.rd   = 1'b1;
            mem_cmd_o.addr = bit_position_i[9:5];
            state_d        = bam_pkg::S_RMW;
          end else begin
            state_d = bam_pkg::S_DONE;
          end
        end
      end

      bam_pkg::S_RMW: begin
        res_d = '{status: bam_pkg::ST_OK, found_position: '0, bit_value: 1'b0};
        mem_cmd_o.addr = pos_q[9:5];
        unique case (func_q)
          bam_pkg::FN_SET: begin
            mem_cmd_o.wr    = 1'b1;
            mem_cmd_o.wdata = mem_rdata_i | bit_sel;
          end
          bam_pkg::FN_CLEAR: begin
            mem_cmd_o.wr    = 1'b1;
            mem_cmd_o.wdata = mem_rdata_i & ~bit_sel;
          end
          bam_pkg::FN_TEST: begin
            res_d.bit_value = mem_rdata_i[pos_q[4:0]];
          end
          default: begin
          end
        endcase
        state_d = bam_pkg::S_DONE;
      end

      bam_pkg::S_SCAN: begin
        // data for word widx_q is in; fetch the next one if the scan goes on
        if (match != '0) begin
          res_d   = '{status: bam_pkg::ST_OK, found_position: {widx_q, first_hit},
                      bit_value: 1'b0};
          state_d = bam_pkg::S_DONE;
        end else if (last_word) begin
          res_d   = '{status: bam_pkg::ST_NOT_FOUND, found_position: '0, bit_value: 1'b0};
          state_d = bam_pkg::S_DONE;
        end else begin
          widx_d         = widx_q + 5'd1;
          mem_cmd_o.rd   = 1'b1;
          mem_cmd_o.addr = widx_q + 5'd1;
        end
      end

      bam_pkg::S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = bam_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bam_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

endmodule

FILE: sv/bitmap_allocation_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocation map core
// Find-first / set / clear / test over a bitmap held in a word RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one operation per beat (func, bit_position, search_value);
//   rsp_o returns exactly one beat per request (status, found_position,
//   bit_value), in request order. cfg_we_i/cfg_wdata_i write the active
//   size in bytes; write it only while no request is in flight.
// Timing: one request at a time. Set, clear and test run a RAM read, then
//   set/clear modify and write the word as the result is registered; an
//   error goes straight to the result. A find reads one 32-bit word per
//   step up to the first hit, at most 32 words. The next request is
//   accepted the cycle after the result moves into the output register.
// Reset: the map reads as all zeros (per-word valid flags, no clearing
//   pass) and the active size returns to 128 bytes.
// Stall: a result held in the output register keeps the sequencer in its
//   done state until rsp_o is taken; no beats are dropped.
// ----------------------------------------------------------------------------
`include "bitmap_allocation_map_core_assert.svh"

module bitmap_allocation_map_core #(
  parameter int unsigned BYTES = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  bam_req_if.sink    req_i,
  bam_rsp_if.source  rsp_o
);

  // positions above 1023 are never reachable, so at most 32 words
  localparam int unsigned FullWords = (BYTES + 3) / 4;
  localparam int unsigned MemWords  = (FullWords > 32) ? 32 : FullWords;

  logic [7:0]                 active_q;
  logic [7:0]                 eff_bytes;
  bam_pkg::mem_cmd_t          mem_cmd;
  logic [bam_pkg::WORD_W-1:0] mem_rdata;
  logic                       res_valid;
  logic                       res_ready;
  bam_pkg::result_t           res;
  logic                       out_valid_q;
  bam_pkg::result_t           out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= bam_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  assign eff_bytes = (32'(active_q) > 32'(BYTES)) ? 8'(BYTES) : active_q;

  bam_map_mem #(
    .Words (MemWords)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mem_cmd),
    .rdata_o (mem_rdata)
  );

  bam_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .eff_bytes_i    (eff_bytes),
    .req_valid_i    (req_i.valid),
    .req_ready_o    (req_i.ready),
    .func_i         (req_i.func),
    .bit_position_i (req_i.bit_position),
    .search_value_i (req_i.search_value),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .mem_cmd_o      (mem_cmd),
    .mem_rdata_i    (mem_rdata)
  );

  // output register parts the sequencer from the response beat
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.found_position = out_q.found_position;
  assign rsp_o.bit_value      = out_q.bit_value;

  // a RAM write always follows the read of the same word
  `BAM_ASSERT(a_wr_after_rd, clk_i, rst_ni, mem_cmd.wr |-> ($past(mem_cmd.rd) && $past(mem_cmd.addr) == mem_cmd.addr))
  // one request in flight: no accept in the cycle after an accept
  `BAM_ASSERT(a_one_in_flight, clk_i, rst_ni, (req_i.valid && req_i.ready) |=> !req_i.ready)
  // only a successful result carries a position or a bit value
  `BAM_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_q && out_q.status != bam_pkg::ST_OK) |-> (out_q.found_position == '0 && !out_q.bit_value))

endmodule

FILE: test/bitmap_allocation_map_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap allocation map core testbench
// A short table of directed operations covers the extremes, every operation,
// size zero, positions out of range and sizes above the store. Random ops
// follow in four pacing phases: no idling, sender idling, receiver stalling,
// then both. Each beat is checked against its fixed row or a shadow bitmap.
// ----------------------------------------------------------------------------
module bitmap_allocation_map_core_tb;

  localparam int unsigned MAP_BYTES = 128;
  localparam int unsigned N_DIRECTED = 25;
  localparam int unsigned N_SEGMENTS = 7;
  localparam int unsigned SEG_ITEMS = 30;

  // one row of the directed table; a size write, when flagged, comes first
  typedef struct packed {
    logic             wr_size;
    logic [7:0]       bytes_in_use;
    bam_pkg::func_e   op;
    logic [9:0]       pos;
    logic             srch;
    logic             fixed;
    bam_pkg::status_e st;
    logic [9:0]       fp;
    logic             bv;
  } step_t;

  typedef struct {
    bit               fixed;
    bam_pkg::result_t res;
  } typed_t;

  localparam step_t DIRECTED [N_DIRECTED] = '{
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd1023, 1'b1, 1'b1, bam_pkg::ST_NOT_FOUND, 10'd0, 1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd0,    1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_TEST,  10'd1023, 1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd1023, 1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_TEST,  10'd1023, 1'b1, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b1},
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd0,    1'b1, 1'b1, bam_pkg::ST_OK,    10'd1023, 1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd0,    1'b1, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd512,  1'b1, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_CLEAR, 10'd0,    1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd341,  1'b0, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd682,  1'b1, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd0,    1'b1, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_CLEAR, 10'd1023, 1'b1, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b1, 8'd0,   bam_pkg::FN_FIND,  10'd0,    1'b0, 1'b1, bam_pkg::ST_ERROR, 10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd5,    1'b0, 1'b1, bam_pkg::ST_ERROR, 10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_TEST,  10'd5,    1'b0, 1'b1, bam_pkg::ST_ERROR, 10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_CLEAR, 10'd5,    1'b1, 1'b1, bam_pkg::ST_ERROR, 10'd0,    1'b0},
    '{1'b1, 8'd1,   bam_pkg::FN_SET,   10'd8,    1'b0, 1'b1, bam_pkg::ST_ERROR, 10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_TEST,  10'd7,    1'b0, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_SET,   10'd7,    1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_FIND,  10'd0,    1'b0, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b1, 8'd200, bam_pkg::FN_TEST,  10'd1023, 1'b0, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b1, 8'd255, bam_pkg::FN_SET,   10'd1023, 1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b0, 8'd0,   bam_pkg::FN_CLEAR, 10'd1023, 1'b0, 1'b1, bam_pkg::ST_OK,    10'd0,    1'b0},
    '{1'b1, 8'd128, bam_pkg::FN_FIND,  10'd0,    1'b1, 1'b0, bam_pkg::ST_OK,    10'd0,    1'b0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  bam_req_if req_if ();
  bam_rsp_if rsp_if ();

  bitmap_allocation_map_core #(
    .BYTES(MAP_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow of the bitmap and the size register
  logic [7:0] shadow_map [MAP_BYTES];
  logic [7:0] shadow_size;

  bam_pkg::result_t expected_results [$];
  typed_t           typed_results [$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_mismatches;
  int unsigned n_size_writes;
  int unsigned n_finds_hit;
  int unsigned n_errors_seen;

  bam_pkg::result_t pred_res;
  bam_pkg::result_t want_res;
  typed_t           note;

  always #4 clk_i = ~clk_i;

  function automatic bam_pkg::result_t predict_map_op(bam_pkg::func_e op, logic [9:0] pos,
                                                      logic want);
    bam_pkg::result_t r;
    int unsigned      eff_bytes;
    int unsigned      bits;
    int unsigned      lim;
    int unsigned      i;
    bit               hit;
    r.status         = bam_pkg::ST_ERROR;
    r.found_position = '0;
    r.bit_value      = 1'b0;
    eff_bytes = shadow_size;
    if (eff_bytes > MAP_BYTES) eff_bytes = MAP_BYTES;
    bits = eff_bytes * 8;
    hit  = 1'b0;
    if (bits != 0) begin
      if (op == bam_pkg::FN_FIND) begin
        lim = (bits < bam_pkg::POS_LIMIT) ? bits : bam_pkg::POS_LIMIT;
        r.status = bam_pkg::ST_NOT_FOUND;
        for (i = 0; i < lim && !hit; i++) begin
          if (shadow_map[i >> 3][i & 7] == want) begin
            hit              = 1'b1;
            r.status         = bam_pkg::ST_OK;
            r.found_position = i[9:0];
          end
        end
      end else if (pos < bits) begin
        case (op)
          bam_pkg::FN_SET:   shadow_map[pos >> 3][pos[2:0]] = 1'b1;
          bam_pkg::FN_CLEAR: shadow_map[pos >> 3][pos[2:0]] = 1'b0;
          default:           r.bit_value = shadow_map[pos >> 3][pos[2:0]];
        endcase
        r.status = bam_pkg::ST_OK;
      end
    end
    return r;
  endfunction

  // receiver: ready drops at random while a stall rate is set
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result beats are checked before the request of the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          n_mismatches++;
          if (n_mismatches <= 10)
            $display("unexpected result beat: status %0d pos %0d bit %0d",
                     rsp_if.status, rsp_if.found_position, rsp_if.bit_value);
        end else begin
          want_res = expected_results.pop_front();
          if (rsp_if.status !== want_res.status ||
              rsp_if.found_position !== want_res.found_position ||
              rsp_if.bit_value !== want_res.bit_value) begin
            n_mismatches++;
            if (n_mismatches <= 10)
              $display("result %0d: expected status %0d pos %0d bit %0d, got %0d %0d %0d",
                       n_checked, want_res.status, want_res.found_position,
                       want_res.bit_value, rsp_if.status, rsp_if.found_position,
                       rsp_if.bit_value);
          end
          if (want_res.status == bam_pkg::ST_ERROR) n_errors_seen++;
        end
        n_checked++;
      end
      if (req_if.valid && req_if.ready) begin
        pred_res = predict_map_op(bam_pkg::func_e'(req_if.func), req_if.bit_position,
                                  req_if.search_value);
        if (bam_pkg::func_e'(req_if.func) == bam_pkg::FN_FIND &&
            pred_res.status == bam_pkg::ST_OK) n_finds_hit++;
        note = typed_results.pop_front();
        expected_results.push_back(note.fixed ? note.res : pred_res);
      end
      if (cfg_we_i) shadow_size = cfg_wdata_i;
    end
  end

  // one request beat, after an optional random gap
  task automatic send_op(bam_pkg::func_e op, logic [9:0] pos, logic srch, bit fixed,
                         bam_pkg::result_t res);
    typed_t t;
    t.fixed = fixed;
    t.res   = res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    typed_results.push_back(t);
    req_if.valid        <= 1'b1;
    req_if.func         <= op;
    req_if.bit_position <= pos;
    req_if.search_value <= srch;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
  endtask

  // size changes only once the map has gone quiet
  task automatic write_size(logic [7:0] bytes_in_use);
    req_if.valid <= 1'b0;
    while (n_checked != n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= bytes_in_use;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    n_size_writes++;
  endtask

  initial begin
    int unsigned      idle_tab [4];
    int unsigned      stall_tab [4];
    int unsigned      bits;
    int unsigned      set_bias;
    int unsigned      pick;
    logic [7:0]       seg_size;
    logic [9:0]       pos;
    bam_pkg::func_e   op;
    bam_pkg::result_t res;
    idle_tab  = '{0, 85, 0, 17};
    stall_tab = '{0, 0, 85, 17};
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_if.valid        = 1'b0;
    req_if.func         = bam_pkg::FN_FIND;
    req_if.bit_position = '0;
    req_if.search_value = 1'b0;
    rsp_if.ready        = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    n_sent              = 0;
    n_checked           = 0;
    n_mismatches        = 0;
    n_size_writes       = 0;
    n_finds_hit         = 0;
    n_errors_seen       = 0;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    shadow_size = bam_pkg::ACTIVE_RESET;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].wr_size) write_size(DIRECTED[k].bytes_in_use);
      res.status         = DIRECTED[k].st;
      res.found_position = DIRECTED[k].fp;
      res.bit_value      = DIRECTED[k].bv;
      send_op(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].srch, DIRECTED[k].fixed, res);
    end

    res = '0;
    for (int unsigned ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      for (int unsigned seg = 0; seg < N_SEGMENTS; seg++) begin
        // small maps fill up and empty out, so not-found finds show up
        pick = $urandom_range(9);
        if (pick == 0)      seg_size = 8'd0;
        else if (pick == 1) seg_size = 8'd128;
        else if (pick == 2) seg_size = 8'($urandom_range(255, 129));
        else if (pick == 3) seg_size = 8'($urandom_range(127, 9));
        else                seg_size = 8'($urandom_range(8, 1));
        write_size(seg_size);
        bits     = ((seg_size > MAP_BYTES) ? MAP_BYTES : seg_size) * 8;
        set_bias = $urandom_range(85, 15);
        for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
          pick = $urandom_range(99);
          if (pick < 25)                           op = bam_pkg::FN_FIND;
          else if (pick < 45)                      op = bam_pkg::FN_TEST;
          else if ($urandom_range(99) < set_bias)  op = bam_pkg::FN_SET;
          else                                     op = bam_pkg::FN_CLEAR;
          if (bits == 0 || $urandom_range(99) < 12) pos = 10'($urandom_range(1023, 0));
          else                                      pos = 10'($urandom_range(bits - 1, 0));
          send_op(op, pos, 1'($urandom_range(1, 0)), 1'b0, res);
        end
      end
    end

    req_if.valid <= 1'b0;
    while (n_checked != n_sent) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("%0d requests, %0d results checked over four pacing phases and %0d size writes",
             n_sent, n_checked, n_size_writes);
    $display("%0d finds hit, %0d error results", n_finds_hit, n_errors_seen);
    if (n_mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching result beats", n_mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
